// ===== design/counter_based_random_word_stream_unit_macros.svh =====
// ----------------------------------------------------------------------------
// counter_based_random_word_stream_unit_macros
// assertion macros shared by the random word stream unit
// ----------------------------------------------------------------------------
`ifndef COUNTER_BASED_RANDOM_WORD_STREAM_UNIT_MACROS_SVH
`define COUNTER_BASED_RANDOM_WORD_STREAM_UNIT_MACROS_SVH

// clocked assertion, off during reset
`define CBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define CBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// cbr_pkg
// types, constants and round helpers of the random word stream unit
// ----------------------------------------------------------------------------
`default_nettype none
package cbr_pkg;

  localparam int ROUNDS = 20;
  localparam int RND_W  = 7;
  localparam logic [63:0] KS_PARITY = 64'h1BD1_1BDA_A9FC_1A22;

  localparam logic [7:0] REG_SEED       = 8'd0;
  localparam logic [7:0] REG_STREAM_KEY = 8'd1;

  typedef struct packed {
    logic [3:0][63:0] x;
    logic [4:0][63:0] ks;
    logic [1:0]       idx;
  } lane_t;

  function automatic logic [5:0] rot_amt(input logic [RND_W-1:0] rnd, input logic sel);
    logic [5:0] a;
    begin
      case (rnd[2:0])
        3'd0: a = sel ? 6'd16 : 6'd14;
        3'd1: a = sel ? 6'd57 : 6'd52;
        3'd2: a = sel ? 6'd40 : 6'd23;
        3'd3: a = sel ? 6'd37 : 6'd5;
        3'd4: a = sel ? 6'd33 : 6'd25;
        3'd5: a = sel ? 6'd12 : 6'd46;
        3'd6: a = sel ? 6'd22 : 6'd58;
        default: a = 6'd32;
      endcase
      return a;
    end
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] n);
    logic [6:0] m;
    begin
      m = 7'd64 - {1'b0, n};
      return (v << n) | (v >> m);
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/counter_based_random_word_stream_unit.sv =====
// ----------------------------------------------------------------------------
// counter_based_random_word_stream_unit
// threefry-4x64 counter based stream of 64-bit random words
//
// channel  dir  signals                          contents
// in       in   in_tvalid/in_tready/in_tdata     tdata: subkey, tuser: mode
// out      out  out_tvalid/out_tready/out_tdata  tdata: random_word
// cfg      in   cfg_valid/cfg_ready              cfg_index, cfg_data
//
// one item accepted per cycle while in_tready is high; each item passes
// through the front stage and one round cell per round
// each item carries its own counter and key through the round chain
// a waiting result with out_tready low freezes the whole chain and holds
// in_tready low
// rst_n synchronous active low; clears stream state, key registers and valids
// ----------------------------------------------------------------------------
`default_nettype none
module counter_based_random_word_stream_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] subkey
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] random_word
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import cbr_pkg::*;

  logic  en;
  logic  v   [ROUNDS+1];
  lane_t ln  [ROUNDS+1];

  assign en        = !v[ROUNDS] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  cbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .take      (in_tvalid && en),
    .mode      (in_tuser),
    .subkey    (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .valid_r   (v[0]),
    .lane_r    (ln[0])
  );

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    cbr_round_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .rnd        (RND_W'(g)),
      .prev_valid (v[g]),
      .prev_lane  (ln[g]),
      .valid_r    (v[g+1]),
      .lane_r     (ln[g+1])
    );
  end

  assign out_tvalid = v[ROUNDS];
  assign out_tdata  = ln[ROUNDS].x[ln[ROUNDS].idx];

endmodule
`default_nettype wire

// ===== design/cbr_round_cell.sv =====
// ----------------------------------------------------------------------------
// cbr_round_cell
// one mix round of the block cipher with key injection after each fourth round
// ----------------------------------------------------------------------------
`default_nettype none
module cbr_round_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [cbr_pkg::RND_W-1:0] rnd,
  input  wire logic                      prev_valid,
  input  wire cbr_pkg::lane_t            prev_lane,
  output logic                           valid_r,
  output cbr_pkg::lane_t                 lane_r
);
  import cbr_pkg::*;

  lane_t                 lane_nxt;
  logic [3:0][63:0]      m;
  logic [RND_W-1:0]      s;
  logic [RND_W-1:0]      rnd_p1;

  assign rnd_p1 = rnd + 1'b1;
  assign s      = rnd_p1 >> 2;

  always_comb begin
    m = prev_lane.x;
    if (!rnd[0]) begin
      m[0] = prev_lane.x[0] + prev_lane.x[1];
      m[1] = rotl(prev_lane.x[1], rot_amt(rnd, 1'b0)) ^ m[0];
      m[2] = prev_lane.x[2] + prev_lane.x[3];
      m[3] = rotl(prev_lane.x[3], rot_amt(rnd, 1'b1)) ^ m[2];
    end else begin
      m[0] = prev_lane.x[0] + prev_lane.x[3];
      m[3] = rotl(prev_lane.x[3], rot_amt(rnd, 1'b0)) ^ m[0];
      m[2] = prev_lane.x[2] + prev_lane.x[1];
      m[1] = rotl(prev_lane.x[1], rot_amt(rnd, 1'b1)) ^ m[2];
    end
    lane_nxt     = prev_lane;
    lane_nxt.x   = m;
    if (rnd[1:0] == 2'd3) begin
      lane_nxt.x[0] = m[0] + prev_lane.ks[0];
      lane_nxt.x[1] = m[1] + prev_lane.ks[1];
      lane_nxt.x[2] = m[2] + prev_lane.ks[2];
      lane_nxt.x[3] = m[3] + prev_lane.ks[3] + {{(64-RND_W){1'b0}}, s};
      // rotate schedule so the next injection uses ks[0..3] again
      lane_nxt.ks   = {prev_lane.ks[0], prev_lane.ks[4], prev_lane.ks[3],
                       prev_lane.ks[2], prev_lane.ks[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/cbr_front.sv =====
// ----------------------------------------------------------------------------
// cbr_front
// stream state, key registers and key whitening ahead of the round chain
// ----------------------------------------------------------------------------
`default_nettype none
`include "counter_based_random_word_stream_unit_macros.svh"
module cbr_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        take,
  input  wire logic        mode,
  input  wire logic [63:0] subkey,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             valid_r,
  output cbr_pkg::lane_t   lane_r
);
  import cbr_pkg::*;

  logic [63:0]  seed_r, stream_key_r, subkey_r, subkey_nxt;
  logic [63:0]  blk_seed_r, blk_seed_nxt, blk_skey_r, blk_skey_nxt;
  logic [255:0] ctr_r, ctr_nxt, ctr_base;
  logic [2:0]   wl_r, wl_nxt, wl_base;
  logic [63:0]  k4;
  lane_t        lane_nxt;

  always_comb begin
    subkey_nxt   = mode ? subkey : subkey_r;
    ctr_base     = mode ? 256'd0 : ctr_r;
    wl_base      = mode ? 3'd0 : wl_r;
    ctr_nxt      = ctr_base;
    wl_nxt       = wl_base;
    blk_seed_nxt = blk_seed_r;
    blk_skey_nxt = blk_skey_r;
    // key is taken from the registers only when a new block starts
    if (wl_base == 3'd0) begin
      ctr_nxt      = ctr_base + 256'd1;
      wl_nxt       = 3'd4;
      blk_seed_nxt = seed_r;
      blk_skey_nxt = stream_key_r;
    end
    wl_nxt = wl_nxt - 3'd1;
    k4     = KS_PARITY ^ blk_skey_nxt ^ subkey_nxt;
    lane_nxt.x[0] = ctr_nxt[63:0]    + blk_seed_nxt;
    lane_nxt.x[1] = ctr_nxt[127:64]  + blk_seed_nxt;
    lane_nxt.x[2] = ctr_nxt[191:128] + blk_skey_nxt;
    lane_nxt.x[3] = ctr_nxt[255:192] + subkey_nxt;
    // schedule held one step ahead: first injection uses ks[1..4]
    lane_nxt.ks   = {blk_seed_nxt, k4, subkey_nxt, blk_skey_nxt, blk_seed_nxt};
    lane_nxt.idx  = wl_nxt[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= 64'd0;
      stream_key_r <= 64'd0;
      subkey_r     <= 64'd0;
      blk_seed_r   <= 64'd0;
      blk_skey_r   <= 64'd0;
      ctr_r        <= 256'd0;
      wl_r         <= 3'd0;
      valid_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_SEED) begin
        seed_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_STREAM_KEY) begin
        stream_key_r <= cfg_data;
      end
      if (take) begin
        subkey_r   <= subkey_nxt;
        blk_seed_r <= blk_seed_nxt;
        blk_skey_r <= blk_skey_nxt;
        ctr_r      <= ctr_nxt;
        wl_r       <= wl_nxt;
      end
      if (en) begin
        valid_r <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  `CBR_ASSERT(a_wl_range, (wl_r <= 3'd3), "words left out of range")
  `CBR_ASSERT(a_restart_fresh, (take && mode |=> wl_r == 3'd3 && ctr_r == 256'd1), "restart did not start a fresh block")
  `CBR_ASSERT(a_draw_dec, (take && !mode && wl_r != 3'd0 |=> wl_r == $past(wl_r) - 3'd1), "draw did not consume a word")
  `CBR_ASSERT_ALWAYS(a_rst_clear, (!rst_n |=> !valid_r), "front stage valid after reset")

endmodule
`default_nettype wire
